// ===== hw/rtl/rau_pkg.sv =====
// Shared widths, operation codes and controller/datapath command types
// for the rational arithmetic unit. No dependencies.
`timescale 1ns / 1ps

package rau_pkg;

	// Operand and result widths
	localparam int OPERAND_WIDTH = 16;
	localparam int OUT_WIDTH     = 33;
	localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
	localparam int MAG_WIDTH     = PROD_WIDTH + 1;
	localparam int SHIFT_WIDTH   = $clog2(MAG_WIDTH + 1);
	localparam int STEP_WIDTH    = $clog2(MAG_WIDTH);
	localparam int WIDE_WIDTH    = MAG_WIDTH + OUT_WIDTH;

	// Operation codes
	typedef logic [1:0] op_t;
	localparam op_t OP_ADD = 2'd0;
	localparam op_t OP_SUB = 2'd1;
	localparam op_t OP_MUL = 2'd2;
	localparam op_t OP_DIV = 2'd3;

	// Kind of result loaded into the output register
	typedef logic [1:0] res_kind_t;
	localparam res_kind_t RES_REDUCED  = 2'd0;
	localparam res_kind_t RES_ZERO     = 2'd1;
	localparam res_kind_t RES_DIV_ZERO = 2'd2;

	// Which partial product the multiplier forms
	typedef logic [1:0] mul_sel_t;
	localparam mul_sel_t MUL_P0 = 2'd0;
	localparam mul_sel_t MUL_P1 = 2'd1;
	localparam mul_sel_t MUL_P2 = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic      load_in;
		logic      mul_en;
		mul_sel_t  mul_sel;
		logic      combine;
		logic      gcd_init;
		logic      gcd_step;
		logic      div_init;
		logic      div_step;
		logic      out_load;
		res_kind_t res_kind;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rn_zero;
		logic rd_zero;
		logic is_div;
		logic gcd_done;
	} dp_status_t;

endpackage

// ===== hw/rtl/rau_req_if.sv =====
// Request channel of the rational arithmetic unit: operation and two fractions.
// Depends on rau_pkg.
`timescale 1ns / 1ps

interface rau_req_if;
	import rau_pkg::*;

	logic                            valid;
	logic                            ready;
	op_t                             cmd;
	logic signed [OPERAND_WIDTH-1:0] num_a;
	logic signed [OPERAND_WIDTH-1:0] den_a;
	logic signed [OPERAND_WIDTH-1:0] num_b;
	logic signed [OPERAND_WIDTH-1:0] den_b;

	modport source (output valid, cmd, num_a, den_a, num_b, den_b, input ready);
	modport sink   (input valid, cmd, num_a, den_a, num_b, den_b, output ready);
endinterface

// ===== hw/rtl/rau_rsp_if.sv =====
// Response channel of the rational arithmetic unit: reduced fraction and
// divide-by-zero flag. Depends on rau_pkg.
`timescale 1ns / 1ps

interface rau_rsp_if;
	import rau_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [OUT_WIDTH-1:0] num_out;
	logic signed [OUT_WIDTH-1:0] den_out;
	logic                        div_zero;

	modport source (output valid, num_out, den_out, div_zero, input ready);
	modport sink   (input valid, num_out, den_out, div_zero, output ready);
endinterface

// ===== hw/rtl/rau_ctrl.sv =====
// Sequencing state machine of the rational arithmetic unit: issues datapath
// commands and owns the handshake flags. Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output rau_pkg::dp_cmd_t    cmd,
	input  rau_pkg::dp_status_t status
);
	import rau_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_COMB  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_GCD   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]            state_q, state_d;
	logic [STEP_WIDTH-1:0] step_q;
	res_kind_t             kind_q, kind_d;
	logic                  out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and command decode
	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		cmd          = '0;
		cmd.mul_sel  = step_q[1:0];
		cmd.res_kind = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				if (step_q == STEP_WIDTH'(MUL_P2))
					state_d = S_COMB;
			end
			S_COMB: begin
				cmd.combine = 1'b1;
				state_d     = S_CHECK;
			end
			S_CHECK: begin
				cmd.gcd_init = 1'b1;
				priority if (status.is_div && status.rd_zero) begin
					kind_d  = RES_DIV_ZERO;
					state_d = S_FIN;
				end else if (status.rn_zero) begin
					kind_d  = RES_ZERO;
					state_d = S_FIN;
				end else begin
					kind_d  = RES_REDUCED;
					state_d = S_GCD;
				end
			end
			S_GCD: begin
				if (status.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_WIDTH'(MAG_WIDTH - 1))
					state_d = S_FIN;
			end
			S_FIN: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, step counter, result kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			kind_q      <= RES_REDUCED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.load_in || cmd.div_init)
				step_q <= '0;
			else if (cmd.mul_en || cmd.div_step)
				step_q <= step_q + 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule

// ===== hw/rtl/rau_datapath.sv =====
// Datapath of the rational arithmetic unit: shared multiplier, sign-magnitude
// combine, binary GCD, two-lane restoring divider and output register.
// Depends on rau_pkg.
`timescale 1ns / 1ps

module rau_datapath (
	input  logic                                     clk,
	input  rau_pkg::dp_cmd_t                         cmd,
	input  rau_pkg::op_t                             op,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] num_a,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] den_a,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] num_b,
	input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] den_b,
	output rau_pkg::dp_status_t                      status,
	output logic signed [rau_pkg::OUT_WIDTH-1:0]     num_out,
	output logic signed [rau_pkg::OUT_WIDTH-1:0]     den_out,
	output logic                                     div_zero
);
	import rau_pkg::*;

	typedef struct packed {
		logic [MAG_WIDTH-1:0] rem;
		logic [MAG_WIDTH-1:0] quo;
	} div_lane_t;

	// Magnitude of a two's complement operand
	function automatic logic [OPERAND_WIDTH-1:0] mag_of(logic [OPERAND_WIDTH-1:0] v);
		return v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	// One restoring division step: shift in the next dividend bit
	function automatic div_lane_t div_lane(div_lane_t cur, logic [MAG_WIDTH-1:0] d);
		logic [MAG_WIDTH:0] t;
		logic               qbit;
		div_lane_t          nxt;
		t = {cur.rem, cur.quo[MAG_WIDTH-1]};
		if (t >= {1'b0, d}) begin
			nxt.rem = MAG_WIDTH'(t - {1'b0, d});
			qbit    = 1'b1;
		end else begin
			nxt.rem = t[MAG_WIDTH-1:0];
			qbit    = 1'b0;
		end
		nxt.quo = {cur.quo[MAG_WIDTH-2:0], qbit};
		return nxt;
	endfunction

	// Sign and magnitude to the result width, wrapping
	function automatic logic [OUT_WIDTH-1:0] to_out(logic neg, logic [MAG_WIDTH-1:0] mag);
		logic [WIDE_WIDTH-1:0] w;
		w = {{OUT_WIDTH{1'b0}}, mag};
		if (neg)
			w = ~w + 1'b1;
		return w[OUT_WIDTH-1:0];
	endfunction

	// Captured operands
	op_t                    op_q;
	logic [OPERAND_WIDTH-1:0] na_mag_q, da_mag_q, nb_mag_q, db_mag_q;
	logic                   na_neg_q, da_neg_q, nb_neg_q, db_neg_q;

	// Partial products
	logic [PROD_WIDTH-1:0]  p0_mag_q, p1_mag_q, p2_mag_q;
	logic                   p0_neg_q, p1_neg_q, p2_neg_q;

	// Raw result
	logic [MAG_WIDTH-1:0]   rn_mag_q, rd_mag_q;
	logic                   rn_neg_q, rd_neg_q;

	// GCD and division
	logic [MAG_WIDTH-1:0]   u_q, v_q, g_q;
	logic [SHIFT_WIDTH-1:0] k_q;
	div_lane_t              ln_q, ld_q;

	// Output register
	logic [OUT_WIDTH-1:0]   num_q, den_q;
	logic                   dz_q;

	// Multiplier operand selection
	logic [OPERAND_WIDTH-1:0] mul_a, mul_b;
	logic                   mul_neg;
	logic [PROD_WIDTH-1:0]  prod;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_P0: begin
				mul_a   = na_mag_q;
				mul_b   = (op_q == OP_MUL) ? nb_mag_q : db_mag_q;
				mul_neg = na_neg_q ^ ((op_q == OP_MUL) ? nb_neg_q : db_neg_q);
			end
			MUL_P1: begin
				mul_a   = nb_mag_q;
				mul_b   = da_mag_q;
				mul_neg = nb_neg_q ^ da_neg_q;
			end
			MUL_P2: begin
				mul_a   = da_mag_q;
				mul_b   = (op_q == OP_DIV) ? nb_mag_q : db_mag_q;
				mul_neg = da_neg_q ^ ((op_q == OP_DIV) ? nb_neg_q : db_neg_q);
			end
			default: begin
				mul_a   = '0;
				mul_b   = '0;
				mul_neg = 1'b0;
			end
		endcase
		prod = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
	end

	// Sign-magnitude combine of the partial products
	logic [MAG_WIDTH-1:0] t0_mag, t1_mag, sum_mag;
	logic                 t0_neg, t1_neg, sum_neg;

	always_comb begin
		t0_mag = {1'b0, p0_mag_q};
		t1_mag = {1'b0, p1_mag_q};
		t0_neg = p0_neg_q && (p0_mag_q != '0);
		t1_neg = (p1_neg_q ^ (op_q == OP_SUB)) && (p1_mag_q != '0);
		priority if (t0_neg == t1_neg) begin
			sum_mag = t0_mag + t1_mag;
			sum_neg = t0_neg;
		end else if (t0_mag >= t1_mag) begin
			sum_mag = t0_mag - t1_mag;
			sum_neg = t0_neg;
		end else begin
			sum_mag = t1_mag - t0_mag;
			sum_neg = t1_neg;
		end
		if (sum_mag == '0)
			sum_neg = 1'b0;
	end

	// Binary GCD step
	logic [MAG_WIDTH-1:0]   u_d, v_d;
	logic [SHIFT_WIDTH-1:0] k_d;

	always_comb begin
		u_d = u_q;
		v_d = v_q;
		k_d = k_q;
		priority if (!u_q[0] && !v_q[0]) begin
			u_d = u_q >> 1;
			v_d = v_q >> 1;
			k_d = k_q + 1'b1;
		end else if (!u_q[0]) begin
			u_d = u_q >> 1;
		end else if (!v_q[0]) begin
			v_d = v_q >> 1;
		end else if (u_q >= v_q) begin
			u_d = (u_q - v_q) >> 1;
		end else begin
			v_d = (v_q - u_q) >> 1;
		end
	end

	assign status.rn_zero  = (rn_mag_q == '0);
	assign status.rd_zero  = (rd_mag_q == '0);
	assign status.is_div   = (op_q == OP_DIV);
	assign status.gcd_done = (u_q == '0) || (v_q == '0);

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= op;
			na_mag_q <= mag_of(num_a);
			da_mag_q <= mag_of(den_a);
			nb_mag_q <= mag_of(num_b);
			db_mag_q <= mag_of(den_b);
			na_neg_q <= num_a[OPERAND_WIDTH-1];
			da_neg_q <= den_a[OPERAND_WIDTH-1];
			nb_neg_q <= num_b[OPERAND_WIDTH-1];
			db_neg_q <= den_b[OPERAND_WIDTH-1];
		end

		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				MUL_P0: begin
					p0_mag_q <= prod;
					p0_neg_q <= mul_neg;
				end
				MUL_P1: begin
					p1_mag_q <= prod;
					p1_neg_q <= mul_neg;
				end
				MUL_P2: begin
					p2_mag_q <= prod;
					p2_neg_q <= mul_neg;
				end
				default: ;
			endcase
		end

		if (cmd.combine) begin
			if (op_q == OP_ADD || op_q == OP_SUB) begin
				rn_mag_q <= sum_mag;
				rn_neg_q <= sum_neg;
			end else begin
				rn_mag_q <= {1'b0, p0_mag_q};
				rn_neg_q <= p0_neg_q && (p0_mag_q != '0);
			end
			rd_mag_q <= {1'b0, p2_mag_q};
			rd_neg_q <= p2_neg_q && (p2_mag_q != '0);
		end

		priority if (cmd.gcd_init) begin
			u_q <= rn_mag_q;
			v_q <= rd_mag_q;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			u_q <= u_d;
			v_q <= v_d;
			k_q <= k_d;
		end

		priority if (cmd.div_init) begin
			g_q    <= (u_q | v_q) << k_q;
			ln_q   <= '{rem: '0, quo: rn_mag_q};
			ld_q   <= '{rem: '0, quo: rd_mag_q};
		end else if (cmd.div_step) begin
			ln_q <= div_lane(ln_q, g_q);
			ld_q <= div_lane(ld_q, g_q);
		end

		// signs trade places between numerator and denominator
		if (cmd.out_load) begin
			unique case (cmd.res_kind)
				RES_REDUCED: begin
					num_q <= to_out(rd_neg_q && (ln_q.quo != '0), ln_q.quo);
					den_q <= to_out(rn_neg_q && (ld_q.quo != '0), ld_q.quo);
					dz_q  <= 1'b0;
				end
				RES_ZERO: begin
					num_q <= '0;
					den_q <= OUT_WIDTH'(1);
					dz_q  <= 1'b0;
				end
				RES_DIV_ZERO: begin
					num_q <= '0;
					den_q <= '0;
					dz_q  <= 1'b1;
				end
				default: begin
					num_q <= '0;
					den_q <= '0;
					dz_q  <= 1'b0;
				end
			endcase
		end
	end

	assign num_out  = num_q;
	assign den_out  = den_q;
	assign div_zero = dz_q;
endmodule

// ===== hw/rtl/rational_arith_unit.sv =====
// Rational arithmetic unit: one operation on two fractions, reduced by the GCD.
// Steps in order: capture, 3 products on one multiplier, combine, check, binary GCD
// steps, then a divider step per bit of the 33-bit quotients, and the output load.
// A zero result or a zero divisor skips the GCD and divider. One item in flight: no
// new request is taken until the last result is in the output register; the
// next is taken while it waits. arst_n clears the controller and output valid only.
`timescale 1ns / 1ps

module rational_arith_unit (
	input logic       clk,
	input logic       arst_n,
	rau_req_if.sink   req,
	rau_rsp_if.source rsp
);
	import rau_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// Sequencer
	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (dp_cmd),
		.status    (dp_status)
	);

	// Arithmetic
	rau_datapath u_datapath (
		.clk      (clk),
		.cmd      (dp_cmd),
		.op       (req.cmd),
		.num_a    (req.num_a),
		.den_a    (req.den_a),
		.num_b    (req.num_b),
		.den_b    (req.den_b),
		.status   (dp_status),
		.num_out  (rsp.num_out),
		.den_out  (rsp.den_out),
		.div_zero (rsp.div_zero)
	);
endmodule
